FILE: rtl/event_priority_queue_macros.svh
// Assertion macros for the event priority queue checker
`ifndef EVENT_PRIORITY_QUEUE_MACROS_SVH
`define EVENT_PRIORITY_QUEUE_MACROS_SVH
// implication checked on every edge outside reset
`define EPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epq check failed");
// next-cycle implication
`define EPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epq check failed");
`endif

FILE: rtl/epq_pkg.sv
// ----------------------------------------------------------------------------
// epq_pkg
// Shared constants and types of the event priority queue.
// ----------------------------------------------------------------------------
package epq_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 59;

    localparam logic       OP_INSERT = 1'b0;
    localparam logic       OP_REMOVE = 1'b1;
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_in;    // capture the input item
        logic write_new;  // store captured item at count
        logic scan_start; // begin min scan at entry 0
        logic scan_step;  // read next entry during scan
        logic shift_step; // move entry up one place
        logic dec_count;
        logic set_result; // latch result with given status
        logic take_entry; // result payload is the found entry
        logic [1:0] status;
    } epq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_remove;
        logic empty;
        logic full;
        logic scan_done;
        logic shift_done;
    } epq_stat_t;
endpackage

FILE: rtl/epq_datapath.sv
// ----------------------------------------------------------------------------
// epq_datapath
// Entry memory, count, minimum scan and gap closing.
// ----------------------------------------------------------------------------
module epq_datapath import epq_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  epq_cmd_t             cmd,
    output epq_stat_t            stat,
    input  logic                 op,
    input  logic [3:0]           event_kind,
    input  logic [15:0]          element_id,
    input  logic [7:0]           port_id,
    input  logic [30:0]          end_time,
    output logic [1:0]           res_status,
    output logic [ENTRY_W-1:0]   res_entry
);
    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic               op_reg;
    logic [ENTRY_W-1:0] item_reg;
    logic [CNT_W-1:0]   ptr_reg;      // next address to read
    logic [ENTRY_W-1:0] rd_reg;       // registered read data
    logic               rd_vld_reg;   // rd_reg holds entry ptr_reg-1
    logic [IDX_W-1:0]   best_reg;
    logic [ENTRY_W-1:0] best_e_reg;
    logic               have_best_reg;
    logic [IDX_W-1:0]   wr_idx_reg;   // shift destination
    logic [ENTRY_W-1:0] res_entry_reg;
    logic [1:0]         res_status_reg;
    logic [CNT_W-1:0]   rd_idx;

    assign rd_idx   = ptr_reg - CNT_W'(1);

    // status toward the controller
    assign stat.is_remove  = op_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CNT_W'(CAPACITY));
    assign stat.scan_done  = rd_vld_reg && (ptr_reg == count_reg);
    assign stat.shift_done = (CNT_W'(wr_idx_reg) + CNT_W'(1) >= count_reg);

    assign res_status = res_status_reg;
    assign res_entry  = res_entry_reg;

    // best index including the entry being compared on the final scan step
    function automatic logic [IDX_W-1:0] best_sel();
        if (!have_best_reg || rd_reg[30:0] < best_e_reg[30:0])
            return IDX_W'(rd_idx);
        return best_reg;
    endfunction

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write_new)
            mem[count_reg[IDX_W-1:0]] <= item_reg;
        else if (cmd.shift_step && rd_vld_reg)
            mem[wr_idx_reg] <= rd_reg;
        rd_reg <= mem[ptr_reg[IDX_W-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg   <= op;
            item_reg <= {event_kind, element_id, port_id, end_time};
        end
        if (cmd.scan_step && rd_vld_reg &&
            (!have_best_reg || rd_reg[30:0] < best_e_reg[30:0]))
        begin
            best_reg   <= IDX_W'(rd_idx);
            best_e_reg <= rd_reg;
        end
        if (cmd.set_result)
        begin
            res_status_reg <= cmd.status;
            res_entry_reg  <= cmd.take_entry ? best_e_reg : '0;
        end
    end

    // count, read pointer and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            have_best_reg <= 1'b0;
            wr_idx_reg    <= '0;
        end
        else
        begin
            if (cmd.write_new)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.dec_count)
                count_reg <= count_reg - CNT_W'(1);
            // new item: point the read port at entry 0 for a possible scan
            if (cmd.load_in)
                ptr_reg <= '0;
            else if (cmd.scan_start)
            begin
                ptr_reg       <= CNT_W'(1);
                rd_vld_reg    <= 1'b1;
                have_best_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (rd_vld_reg)
                    have_best_reg <= 1'b1;
                if (ptr_reg != count_reg)
                    ptr_reg <= ptr_reg + CNT_W'(1);
                if (stat.scan_done)
                begin
                    // start gap closing: read best+1
                    ptr_reg    <= CNT_W'(best_sel()) + CNT_W'(1);
                    wr_idx_reg <= best_sel();
                    rd_vld_reg <= 1'b0;
                end
            end
            else if (cmd.shift_step)
            begin
                if (rd_vld_reg)
                    wr_idx_reg <= wr_idx_reg + IDX_W'(1);
                rd_vld_reg <= 1'b1;
                ptr_reg    <= ptr_reg + CNT_W'(1);
            end
        end
    end
endmodule

FILE: rtl/epq_ctrl.sv
// ----------------------------------------------------------------------------
// epq_ctrl
// Sequencer for insert, minimum scan, gap closing and result delivery.
// ----------------------------------------------------------------------------
module epq_ctrl import epq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  epq_stat_t stat,
    output epq_cmd_t  cmd
);
    typedef enum logic [2:0] {IDLE, DECIDE, SCAN, SCAN_END, SHIFT, DONE} state_t;
    state_t state_reg;
    logic   out_valid_reg;

    // a new item enters once the previous result is gone or leaving
    assign in_ready  = (state_reg == IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // command decode
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            IDLE:     cmd.load_in = in_valid && in_ready;
            DECIDE:
            begin
                if (!stat.is_remove)
                begin
                    cmd.set_result = 1'b1;
                    cmd.status     = stat.full ? ST_FULL : ST_OK;
                    cmd.write_new  = !stat.full;
                end
                else if (stat.empty)
                begin
                    cmd.set_result = 1'b1;
                    cmd.status     = ST_EMPTY;
                end
                else
                    cmd.scan_start = 1'b1;
            end
            SCAN:     cmd.scan_step = 1'b1;
            SCAN_END:
            begin
                cmd.set_result = 1'b1;
                cmd.take_entry = 1'b1;
                cmd.status     = ST_OK;
                cmd.shift_step = 1'b1;
            end
            SHIFT:
            begin
                cmd.shift_step = !stat.shift_done;
                cmd.dec_count  = stat.shift_done;
            end
            DONE:     cmd = '0;
            default:  cmd = '0;
        endcase
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                IDLE:     if (in_valid && in_ready) state_reg <= DECIDE;
                DECIDE:
                begin
                    if (stat.is_remove && !stat.empty)
                        state_reg <= SCAN;
                    else
                    begin
                        state_reg     <= IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                SCAN:     if (stat.scan_done) state_reg <= SCAN_END;
                SCAN_END:
                begin
                    state_reg     <= SHIFT;
                    out_valid_reg <= 1'b1;
                end
                SHIFT:    if (stat.shift_done) state_reg <= DONE;
                DONE:     state_reg <= IDLE;
                default:  state_reg <= IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/event_priority_queue.sv
// ----------------------------------------------------------------------------
// event_priority_queue
// Stable min queue of simulator events keyed by end time, FIFO among ties.
// ----------------------------------------------------------------------------
// channel  signals                                         direction
// input    in_valid/in_ready, op, event_kind..end_time     into block
// output   out_valid/out_ready, status, out_*              out of block
//
// Insert, or remove on empty: the outcome is decided in DECIDE and the result
// is registered as the block returns to IDLE, where the next item can be taken.
// Remove: SCAN reads every stored entry through the registered read port;
// SCAN_END latches the earliest minimum as the result, which becomes valid as
// SHIFT begins closing the gap behind it; the next item is taken after DONE.
// A stalled result blocks the input: no item is taken until it leaves.
// Reset empties the queue at once; memory contents are not cleared.
module event_priority_queue import epq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [3:0]  event_kind,
    input  logic [15:0] element_id,
    input  logic [7:0]  port_id,
    input  logic [30:0] end_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  out_event_kind,
    output logic [15:0] out_element_id,
    output logic [7:0]  out_port_id,
    output logic [30:0] out_end_time
);
    epq_cmd_t           cmd;
    epq_stat_t          stat;
    logic [ENTRY_W-1:0] res_entry;

    epq_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
        .stat, .cmd
    );

    epq_datapath u_dp (
        .clk, .rst_n, .cmd, .stat, .op, .event_kind, .element_id,
        .port_id, .end_time, .res_status(status), .res_entry
    );

    assign out_event_kind = res_entry[58:55];
    assign out_element_id = res_entry[54:39];
    assign out_port_id    = res_entry[38:31];
    assign out_end_time   = res_entry[30:0];
endmodule

FILE: rtl/epq_checker.sv
// ----------------------------------------------------------------------------
// epq_checker
// Port-level checks of the event priority queue.
// ----------------------------------------------------------------------------
`include "event_priority_queue_macros.svh"
module epq_checker import epq_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [30:0] out_end_time
);
    // stalled result holds
    `EPQ_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(status))
    // no new item accepted in the cycle after one
    `EPQ_ASSERT_NXT(a_seq, in_valid && in_ready, !in_ready)
    // status code is in range
    `EPQ_ASSERT_IMP(a_code, out_valid, status != 2'd3)
    // non-ok result carries zero payload
    `EPQ_ASSERT_IMP(a_zero, out_valid && status != ST_OK, out_end_time == '0)
endmodule

bind event_priority_queue epq_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .out_end_time
);
